### hw/rtl/tsac_pkg.sv
// Shared types and constants of the trajectory speed and acceleration checker.
package tsac_pkg;

    // Default parameter values.
    localparam int DEF_COORD_BITS = 24;
    localparam int DEF_WINDOW_MAX = 64;

    // Value ranges.
    localparam logic [23:0] VAL_MAX = 24'hFFFFFF;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Configuration register reset values.
    localparam logic [9:0]  RST_STEP_RATE   = 10'd50;
    localparam logic [6:0]  RST_AVG_WINDOW  = 7'd10;
    localparam logic [23:0] RST_SPEED_LIMIT = 24'd5632;
    localparam logic [23:0] RST_ACCEL_LIMIT = 24'd2304;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_STEP_RATE   = 2'd0,
        CFG_AVG_WINDOW  = 2'd1,
        CFG_SPEED_LIMIT = 2'd2,
        CFG_ACCEL_LIMIT = 2'd3
    } t_cfg_idx;

    // Iterative unit widths and step counts.
    localparam int ITER_W = 48;
    localparam int DEN_W  = 24;
    localparam logic [5:0] STEPS_SQRT  = 6'd24;
    localparam logic [5:0] STEPS_AVG   = 6'd32;
    localparam logic [5:0] STEPS_ACCEL = 6'd34;
    localparam logic [5:0] STEPS_RATIO = 6'd40;

    // Request to the shared iterative unit.
    typedef struct packed {
        logic       start;
        logic       is_sqrt;
        logic [5:0] steps;
    } t_iter_req;

endpackage

### hw/rtl/tsac_in_if.sv
// Input channel: one path point per transaction.
interface tsac_in_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic                         last;

    modport source (output valid, output pos_x, output pos_y, output last, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input last, output ready);
endinterface

### hw/rtl/tsac_out_if.sv
// Output channel: one ratio and peak report per transaction.
interface tsac_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] speed_ratio;
    logic [16:0] accel_ratio;
    logic [23:0] peak_speed;
    logic [23:0] peak_accel;

    modport source (output valid, output speed_ratio, output accel_ratio,
                    output peak_speed, output peak_accel, input ready);
    modport sink   (input valid, input speed_ratio, input accel_ratio,
                    input peak_speed, input peak_accel, output ready);
endinterface

### hw/rtl/tsac_iter.sv
// Shared iterative unit: restoring division one bit a cycle, square root two bits a cycle.
module tsac_iter
    import tsac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_iter_req         i_req,
    input  logic [ITER_W-1:0] i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [ITER_W-1:0] o_quo
);
    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic              r_sqrt;
    logic [ITER_W-1:0] r_num;
    logic [ITER_W-1:0] r_q;
    logic [25:0]       r_rem;
    logic [DEN_W-1:0]  r_den;

    logic [27:0] cand;
    logic [27:0] trial;
    logic [27:0] diff;
    logic        ge;

    // One step: shift in the next numerator bits and try a subtraction.
    always_comb begin
        if (r_sqrt) begin
            cand  = {r_rem, r_num[ITER_W-1 -: 2]};
            trial = {2'b00, r_q[23:0], 2'b01};
        end else begin
            cand  = {1'b0, r_rem, r_num[ITER_W-1]};
            trial = {4'b0000, r_den};
        end
        ge   = (cand >= trial);
        diff = cand - trial;
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.is_sqrt;
            r_num  <= i_num;
            r_den  <= i_den;
            r_q    <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_num <= r_sqrt ? {r_num[ITER_W-3:0], 2'b00} : {r_num[ITER_W-2:0], 1'b0};
            r_q   <= {r_q[ITER_W-2:0], ge};
            r_rem <= ge ? diff[25:0] : cand[25:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

### hw/rtl/trajectory_speed_accel_checker_top.sv
// Top level of the trajectory speed and acceleration checker.
//
// One point is taken per input transaction; the block is busy until the point is done.
// The first point of a path is only stored. Any other point without a closing window
// keeps it busy for the squares, the step rate products and the speed square root; a huge
// step or a zero step rate skips the products and the square root. A point that closes a
// window adds the window average and, from the second window on, the acceleration
// division. The point marked last adds up to two ratio divisions, then offers one result,
// and waits while an earlier result has not yet been taken.
// All square roots and divisions run one after another through a single iterative
// unit, squares through one 24 by 24 multiplier and products with the step rate
// through one 48 by 10 multiplier.
module trajectory_speed_accel_checker_top
    import tsac_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int WINDOW_MAX = DEF_WINDOW_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    tsac_in_if.sink     i_pt,
    tsac_out_if.source  o_res
);
    localparam int WBITS = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = 24 + $clog2(WINDOW_MAX);

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_SQX   = 17'h00002,
        S_SQY   = 17'h00004,
        S_MR1   = 17'h00008,
        S_MR2   = 17'h00010,
        S_MR3   = 17'h00020,
        S_SQRT  = 17'h00040,
        S_ACCUM = 17'h00080,
        S_AVG   = 17'h00100,
        S_ACCM  = 17'h00200,
        S_ACCD  = 17'h00400,
        S_ACCW  = 17'h00800,
        S_CHKL  = 17'h01000,
        S_RSW   = 17'h02000,
        S_RA0   = 17'h04000,
        S_RAW   = 17'h08000,
        S_OUT   = 17'h10000
    } t_state;

    // Configuration registers.
    logic [9:0]  r_step_rate;
    logic [6:0]  r_avg_window;
    logic [23:0] r_speed_limit;
    logic [23:0] r_accel_limit;

    // Path state.
    t_state                  r_state, n_state;
    logic [COORD_BITS-1:0]   r_prev_x, r_prev_y;
    logic                    r_have_prev;
    logic [WBITS-1:0]        r_cnt;
    logic [SUM_W-1:0]        r_sum;
    logic [23:0]             r_prev_avg;
    logic                    r_have_avg;
    logic [23:0]             r_max_spd;
    logic [23:0]             r_max_acc;

    // Working registers.
    logic [COORD_BITS-1:0]   r_ax, r_ay;
    logic                    r_last;
    logic [48:0]             r_d2;
    logic [57:0]             r_p;
    logic [23:0]             r_spd;
    logic [23:0]             r_diff;
    logic [16:0]             r_srat, r_arat;

    // Output register.
    logic                    r_out_valid;
    logic [16:0]             r_out_srat, r_out_arat;
    logic [23:0]             r_out_pspd, r_out_pacc;

    // Shared units.
    t_iter_req         iter_req;
    logic [ITER_W-1:0] iter_num;
    logic [DEN_W-1:0]  iter_den;
    logic              iter_done;
    logic [ITER_W-1:0] iter_quo;
    logic [23:0]       sq_a;
    logic [47:0]       sq_p;
    logic [47:0]       rm_a;
    logic [57:0]       rm_p;

    // Derived values.
    logic [WBITS-1:0]      w;
    logic [8:0]            aw9;
    logic [COORD_BITS:0]   dx, dy;
    logic [32:0]           ax33, ay33;
    logic                  huge;
    logic                  p_ovf;
    logic [WBITS-1:0]      cnt_inc;
    logic                  win_close;
    logic [SUM_W-1:0]      sum_inc;
    logic [23:0]           avg;
    logic [23:0]           acc;
    logic                  accept;
    logic                  out_load;

    assign accept   = i_pt.valid && i_pt.ready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_res.ready);

    // Window length clamped to one through the maximum.
    always_comb begin
        aw9 = 9'(r_avg_window);
        if (aw9 == 9'd0) begin
            w = WBITS'(1);
        end else if (aw9 > 9'(WINDOW_MAX)) begin
            w = WBITS'(WINDOW_MAX);
        end else begin
            w = WBITS'(aw9);
        end
    end

    // Step deltas against the previous point.
    assign dx = {i_pt.pos_x[COORD_BITS-1], i_pt.pos_x} - {r_prev_x[COORD_BITS-1], r_prev_x};
    assign dy = {i_pt.pos_y[COORD_BITS-1], i_pt.pos_y} - {r_prev_y[COORD_BITS-1], r_prev_y};

    assign ax33  = 33'(r_ax);
    assign ay33  = 33'(r_ay);
    assign huge  = (|ax33[32:24]) || (|ay33[32:24]);
    assign p_ovf = |r_p[57:48];

    assign cnt_inc   = r_cnt + WBITS'(1);
    assign win_close = ({1'b0, cnt_inc} >= {1'b0, w});
    assign sum_inc   = r_sum + SUM_W'(r_spd);
    assign avg       = iter_quo[23:0];
    assign acc       = (|iter_quo[33:24]) ? VAL_MAX : iter_quo[23:0];

    // Squarer for the step deltas.
    assign sq_a = (r_state == S_SQY) ? ay33[23:0] : ax33[23:0];
    assign sq_p = 48'(sq_a) * 48'(sq_a);

    // Step rate multiplier operand selection.
    always_comb begin
        unique case (r_state)
            S_MR1:   rm_a = r_d2[47:0];
            S_MR2:   rm_a = r_p[47:0];
            S_ACCM:  rm_a = 48'(r_diff);
            default: rm_a = '0;
        endcase
    end
    assign rm_p = 58'(rm_a) * 58'(r_step_rate);

    // Sequencer and requests to the iterative unit.
    always_comb begin
        n_state  = r_state;
        iter_req = '0;
        iter_num = '0;
        iter_den = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = r_have_prev ? S_SQX : S_CHKL;
                end
            end
            S_SQX: begin
                n_state = (r_step_rate == 10'd0 || huge) ? S_ACCUM : S_SQY;
            end
            S_SQY: n_state = S_MR1;
            S_MR1: n_state = r_d2[48] ? S_ACCUM : S_MR2;
            S_MR2: n_state = p_ovf ? S_ACCUM : S_MR3;
            S_MR3: begin
                if (p_ovf) begin
                    n_state = S_ACCUM;
                end else begin
                    iter_req = '{start: 1'b1, is_sqrt: 1'b1, steps: STEPS_SQRT};
                    iter_num = r_p[47:0];
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: if (iter_done) n_state = S_ACCUM;
            S_ACCUM: begin
                if (win_close) begin
                    iter_req = '{start: 1'b1, is_sqrt: 1'b0, steps: STEPS_AVG};
                    iter_num = {32'(sum_inc), 16'h0000};
                    iter_den = DEN_W'(w);
                    n_state  = S_AVG;
                end else begin
                    n_state = S_CHKL;
                end
            end
            S_AVG: if (iter_done) n_state = r_have_avg ? S_ACCM : S_CHKL;
            S_ACCM: n_state = S_ACCD;
            S_ACCD: begin
                iter_req = '{start: 1'b1, is_sqrt: 1'b0, steps: STEPS_ACCEL};
                iter_num = {r_p[33:0], 14'h0000};
                iter_den = DEN_W'(w);
                n_state  = S_ACCW;
            end
            S_ACCW: if (iter_done) n_state = S_CHKL;
            S_CHKL: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (r_max_spd > r_speed_limit) begin
                    iter_req = '{start: 1'b1, is_sqrt: 1'b0, steps: STEPS_RATIO};
                    iter_num = {r_speed_limit, 24'h000000};
                    iter_den = r_max_spd;
                    n_state  = S_RSW;
                end else begin
                    n_state = S_RA0;
                end
            end
            S_RSW: if (iter_done) n_state = S_RA0;
            S_RA0: begin
                if (r_max_acc > r_accel_limit) begin
                    iter_req = '{start: 1'b1, is_sqrt: 1'b0, steps: STEPS_RATIO};
                    iter_num = {r_accel_limit, 24'h000000};
                    iter_den = r_max_acc;
                    n_state  = S_RAW;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RAW: if (iter_done) n_state = S_OUT;
            S_OUT: if (!r_out_valid || o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_rate   <= RST_STEP_RATE;
            r_avg_window  <= RST_AVG_WINDOW;
            r_speed_limit <= RST_SPEED_LIMIT;
            r_accel_limit <= RST_ACCEL_LIMIT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STEP_RATE:   r_step_rate   <= i_cfg_data[9:0];
                CFG_AVG_WINDOW:  r_avg_window  <= i_cfg_data[6:0];
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data;
                CFG_ACCEL_LIMIT: r_accel_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Path state and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_prev_avg  <= '0;
            r_have_avg  <= 1'b0;
            r_max_spd   <= '0;
            r_max_acc   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (accept) r_have_prev <= 1'b1;
                S_ACCUM: begin
                    if (r_spd > r_max_spd) r_max_spd <= r_spd;
                    if (win_close) begin
                        r_sum <= '0;
                        r_cnt <= '0;
                    end else begin
                        r_sum <= sum_inc;
                        r_cnt <= cnt_inc;
                    end
                end
                S_AVG: begin
                    if (iter_done) begin
                        r_prev_avg <= avg;
                        r_have_avg <= 1'b1;
                    end
                end
                S_ACCW: if (iter_done && acc > r_max_acc) r_max_acc <= acc;
                S_OUT: begin
                    if (out_load) begin
                        r_have_prev <= 1'b0;
                        r_cnt       <= '0;
                        r_sum       <= '0;
                        r_prev_avg  <= '0;
                        r_have_avg  <= 1'b0;
                        r_max_spd   <= '0;
                        r_max_acc   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working data.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_prev_x <= i_pt.pos_x;
                    r_prev_y <= i_pt.pos_y;
                    r_last   <= i_pt.last;
                    r_ax     <= dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
                    r_ay     <= dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
                    r_srat   <= ONE_Q16;
                    r_arat   <= ONE_Q16;
                end
            end
            S_SQX: begin
                r_d2 <= 49'(sq_p);
                if (r_step_rate == 10'd0) begin
                    r_spd <= '0;
                end else if (huge) begin
                    r_spd <= VAL_MAX;
                end
            end
            S_SQY: r_d2 <= r_d2 + 49'(sq_p);
            S_MR1: begin
                r_p <= rm_p;
                if (r_d2[48]) r_spd <= VAL_MAX;
            end
            S_MR2: begin
                r_p <= rm_p;
                if (p_ovf) r_spd <= VAL_MAX;
            end
            S_MR3: if (p_ovf) r_spd <= VAL_MAX;
            S_SQRT: if (iter_done) r_spd <= iter_quo[23:0];
            S_AVG: r_diff <= (avg > r_prev_avg) ? avg - r_prev_avg : r_prev_avg - avg;
            S_ACCM: r_p <= rm_p;
            S_RSW: if (iter_done) r_srat <= iter_quo[16:0];
            S_RAW: if (iter_done) r_arat <= iter_quo[16:0];
            S_OUT: begin
                if (out_load) begin
                    r_out_srat <= r_srat;
                    r_out_arat <= r_arat;
                    r_out_pspd <= r_max_spd;
                    r_out_pacc <= r_max_acc;
                    r_prev_x   <= '0;
                    r_prev_y   <= '0;
                end
            end
            default: ;
        endcase
    end

    tsac_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .i_num   (iter_num),
        .i_den   (iter_den),
        .o_done  (iter_done),
        .o_quo   (iter_quo)
    );

    assign i_pt.ready        = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.speed_ratio = r_out_srat;
    assign o_res.accel_ratio = r_out_arat;
    assign o_res.peak_speed  = r_out_pspd;
    assign o_res.peak_accel  = r_out_pacc;
endmodule

### hw/rtl/tsac_chk.sv
// Port-level assertions for the checker top level, with the bind that attaches them.
module tsac_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [16:0] i_speed_ratio,
    input logic [16:0] i_accel_ratio,
    input logic [23:0] i_peak_speed,
    input logic [23:0] i_peak_accel
);
    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_peak_speed)
            && $stable(i_peak_accel) && $stable(i_speed_ratio) && $stable(i_accel_ratio))
        else $error("result changed while stalled");

    // Each point keeps the block busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after a transaction");

    // Ratios never exceed one.
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_speed_ratio <= 17'h10000 && i_accel_ratio <= 17'h10000)
        else $error("ratio above one");

    // A zero peak is always within the limit.
    a_zero_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_peak_speed == 24'd0 |-> i_speed_ratio == 17'h10000)
        else $error("zero speed peak gave a reduced ratio");

    // No result right after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind trajectory_speed_accel_checker_top tsac_chk u_tsac_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pt.valid),
    .i_in_ready    (i_pt.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_speed_ratio (o_res.speed_ratio),
    .i_accel_ratio (o_res.accel_ratio),
    .i_peak_speed  (o_res.peak_speed),
    .i_peak_accel  (o_res.peak_accel)
);

### tb/trajectory_speed_accel_checker_top_chk.sv
// Checker: watches both channels, predicts each report and compares it.
module trajectory_speed_accel_checker_top_chk
    import tsac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_pt_valid,
    input  logic        i_pt_ready,
    input  logic [23:0] i_pt_x,
    input  logic [23:0] i_pt_y,
    input  logic        i_pt_last,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [16:0] i_speed_ratio,
    input  logic [16:0] i_accel_ratio,
    input  logic [23:0] i_peak_speed,
    input  logic [23:0] i_peak_accel,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [16:0] speed_ratio;
        logic [16:0] accel_ratio;
        logic [23:0] peak_speed;
        logic [23:0] peak_accel;
    } t_report;

    t_report report_q[$];

    // Shadow configuration and path state.
    logic [63:0] rate, win, slim, alim;
    longint      last_x, last_y;
    bit          have_pt, have_avg;
    logic [63:0] win_cnt, spd_sum, last_avg, top_spd, top_acc;

    assign o_pending = report_q.size();

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] limit_ratio(logic [63:0] lim, logic [63:0] pk);
        if (pk > lim) return (lim * 64'd65536) / pk;
        return 64'd65536;
    endfunction

    function automatic logic [63:0] point_speed(longint dx, longint dy);
        logic [63:0] ax, ay, d2, r2;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (rate == 0) return 0;
        if (ax > VAL_MAX || ay > VAL_MAX) return VAL_MAX;
        d2 = ax * ax + ay * ay;
        r2 = rate * rate;
        if (d2 > ((64'd1 << 48) - 1) / r2) return VAL_MAX;
        return isqrt(d2 * r2);
    endfunction

    // Advance the shadow path state by one point and queue a report on the last one.
    task automatic track_point(longint x, longint y, bit fin);
        logic [63:0] w, s, a, d, acc;
        t_report r;
        w = win < 1 ? 1 : (win > DEF_WINDOW_MAX ? DEF_WINDOW_MAX : win);
        if (have_pt) begin
            s = point_speed(x - last_x, y - last_y);
            if (s > top_spd) top_spd = s;
            spd_sum += s;
            win_cnt++;
            if (win_cnt >= w) begin
                a = spd_sum / w;
                if (have_avg) begin
                    d = a > last_avg ? a - last_avg : last_avg - a;
                    acc = d * rate / w;
                    if (acc > VAL_MAX) acc = VAL_MAX;
                    if (acc > top_acc) top_acc = acc;
                end
                last_avg = a;
                have_avg = 1;
                spd_sum = 0;
                win_cnt = 0;
            end
        end
        last_x = x;
        last_y = y;
        have_pt = 1;
        if (fin) begin
            r.speed_ratio = 17'(limit_ratio(slim, top_spd));
            r.accel_ratio = 17'(limit_ratio(alim, top_acc));
            r.peak_speed  = 24'(top_spd);
            r.peak_accel  = 24'(top_acc);
            report_q = {report_q, r};
            have_pt = 0; have_avg = 0; win_cnt = 0; spd_sum = 0;
            last_avg = 0; top_spd = 0; top_acc = 0; last_x = 0; last_y = 0;
        end
    endtask

    // Observe configuration writes, points and reports at each rising edge.
    always @(posedge i_clk) begin
        t_report got, exp_r;
        if (!i_rst_n) begin
            rate = RST_STEP_RATE; win = RST_AVG_WINDOW;
            slim = RST_SPEED_LIMIT; alim = RST_ACCEL_LIMIT;
            have_pt = 0; have_avg = 0; win_cnt = 0; spd_sum = 0;
            last_avg = 0; top_spd = 0; top_acc = 0; last_x = 0; last_y = 0;
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_STEP_RATE:   rate = i_cfg_data[9:0];
                    CFG_AVG_WINDOW:  win  = i_cfg_data[6:0];
                    CFG_SPEED_LIMIT: slim = i_cfg_data;
                    CFG_ACCEL_LIMIT: alim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pt_valid && i_pt_ready)
                track_point(longint'($signed(i_pt_x)), longint'($signed(i_pt_y)), i_pt_last);
            if (i_res_valid && i_res_ready) begin
                got = {i_speed_ratio, i_accel_ratio, i_peak_speed, i_peak_accel};
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected report, expected none, actual %h", $time, got);
                    o_errors++;
                end else begin
                    exp_r = report_q.pop_front();
                    if (got.speed_ratio !== exp_r.speed_ratio) begin
                        $display("%0t: speed_ratio expected %0d actual %0d", $time,
                                 exp_r.speed_ratio, got.speed_ratio);
                        o_errors++;
                    end
                    if (got.accel_ratio !== exp_r.accel_ratio) begin
                        $display("%0t: accel_ratio expected %0d actual %0d", $time,
                                 exp_r.accel_ratio, got.accel_ratio);
                        o_errors++;
                    end
                    if (got.peak_speed !== exp_r.peak_speed) begin
                        $display("%0t: peak_speed expected %0d actual %0d", $time,
                                 exp_r.peak_speed, got.peak_speed);
                        o_errors++;
                    end
                    if (got.peak_accel !== exp_r.peak_accel) begin
                        $display("%0t: peak_accel expected %0d actual %0d", $time,
                                 exp_r.peak_accel, got.peak_accel);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

### tb/trajectory_speed_accel_checker_top_test.sv
// Testbench top: drives paths and configuration into the checker block and gives the verdict.
module trajectory_speed_accel_checker_top_test;
    import tsac_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = 0;
    logic [23:0] i_cfg_data = 0;
    int          errors, pending;
    int          idle_cycles = 0;
    bit          hold_off = 0;

    tsac_in_if  pt_if ();
    tsac_out_if res_if ();

    trajectory_speed_accel_checker_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pt(pt_if.sink), .o_res(res_if.source)
    );

    trajectory_speed_accel_checker_top_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_pt_valid(pt_if.valid), .i_pt_ready(pt_if.ready),
        .i_pt_x(pt_if.pos_x), .i_pt_y(pt_if.pos_y), .i_pt_last(pt_if.last),
        .i_res_valid(res_if.valid), .i_res_ready(res_if.ready),
        .i_speed_ratio(res_if.speed_ratio), .i_accel_ratio(res_if.accel_ratio),
        .i_peak_speed(res_if.peak_speed), .i_peak_accel(res_if.peak_accel),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        pt_if.valid = 0; pt_if.pos_x = 0; pt_if.pos_y = 0; pt_if.last = 0;
        res_if.ready = 0;
    end

    // Watchdog: counts cycles without any transaction.
    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("trajectory_speed_accel_checker_top_test: errors");
            $finish;
        end
    end

    // Report receiver with random stalls, and one long hold-off on request.
    initial begin
        int gap;
        bit held;
        held = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off && !held) begin
                res_if.ready <= 0;
                repeat (3000) @(negedge i_clk);
                held = 1;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                res_if.ready <= 0;
                repeat (gap - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            res_if.ready <= 1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // Offer one point after a random gap (none when busy is set) and wait for its transaction.
    task automatic send_point(logic [23:0] x, logic [23:0] y, bit fin, bit busy);
        int gap;
        gap = busy ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            pt_if.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        pt_if.valid <= 1; pt_if.pos_x <= x; pt_if.pos_y <= y; pt_if.last <= fin;
        do @(posedge i_clk); while (!(pt_if.valid && pt_if.ready));
    endtask

    task automatic drain();
        @(negedge i_clk);
        pt_if.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    // Random path around a start point; steps mostly small, sometimes large.
    task automatic random_path(int len, bit busy);
        logic [23:0] x, y;
        int k;
        x = $urandom; y = $urandom;
        for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0: begin x = $urandom; y = $urandom; end
                1, 2: begin x += $urandom_range(0, 8191) - 4096; y += $urandom_range(0, 8191) - 4096; end
                default: begin x += $urandom_range(0, 255) - 128; y += $urandom_range(0, 255) - 128; end
            endcase
            send_point(x, y, k == len - 1, busy);
        end
    endtask

    initial begin
        int ph, n;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: default settings, single point, extremes of the coordinates.
        send_point(24'h000000, 24'h000000, 1, 0);
        send_point(24'h7FFFFF, 24'h800000, 0, 0);
        send_point(24'h800000, 24'h7FFFFF, 0, 0);
        send_point(24'h000000, 24'h000000, 1, 0);
        send_point(24'hFFFFFF, 24'h000001, 0, 0);
        send_point(24'h000010, 24'hFFFFF0, 1, 0);
        drain();
        // Zero step rate, window of zero (counts as one), limits at the extremes.
        write_reg(CFG_STEP_RATE, 0);
        write_reg(CFG_AVG_WINDOW, 0);
        write_reg(CFG_SPEED_LIMIT, 24'hFFFFFF);
        write_reg(CFG_ACCEL_LIMIT, 1);
        random_path(5, 0);
        drain();
        // Step rate of 1000, window above the maximum, window shortened mid-path.
        write_reg(CFG_STEP_RATE, 1000);
        write_reg(CFG_AVG_WINDOW, 127);
        write_reg(CFG_SPEED_LIMIT, 1);
        write_reg(CFG_ACCEL_LIMIT, 24'hFFFFFF);
        random_path(6, 0);
        drain();
        write_reg(CFG_AVG_WINDOW, 3);
        for (n = 0; n < 4; n++) send_point(n * 300, n * n * 100, 0, 0);
        drain();
        write_reg(CFG_AVG_WINDOW, 1);
        send_point(24'h000500, 24'h000000, 1, 0);
        drain();

        // Random phases with fresh settings; one phase holds the receiver off.
        for (ph = 0; ph < 12; ph++) begin
            write_reg(CFG_STEP_RATE, $urandom_range(0, 5) == 0 ? $urandom_range(0, 1023)
                                                               : $urandom_range(1, 100));
            write_reg(CFG_AVG_WINDOW, $urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                                                : $urandom_range(1, 6));
            write_reg(CFG_SPEED_LIMIT, $urandom_range(1, 3) == 1 ? $urandom : $urandom_range(1, 40000));
            write_reg(CFG_ACCEL_LIMIT, $urandom_range(1, 3) == 1 ? $urandom : $urandom_range(1, 40000));
            if (ph == 4) hold_off = 1;
            n = 0;
            while (n < 70) begin
                int len;
                len = $urandom_range(0, 6) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 15);
                random_path(len, ph == 4);
                n += len;
            end
            drain();
        end
        if (errors == 0)
            $display("trajectory_speed_accel_checker_top_test: clean");
        else
            $display("trajectory_speed_accel_checker_top_test: errors");
        $finish;
    end
endmodule
